[rtl/cdeq_pkg.sv]
package cdeq_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // shift command broadcast to every cell; at most one bit is set
    typedef struct packed {
        logic add_front;
        logic add_back;
        logic take_front;
        logic take_back;
    } t_cell_ctrl;

endpackage

[rtl/cdeq_if.sv]
interface cdeq_op_if import cdeq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        operation;
    logic [DATA_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface cdeq_res_if import cdeq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] front_value;
    logic [DATA_W-1:0] back_value;
    logic [CNT_W-1:0]  entry_count;
    logic [1:0]        status;

    modport source (output valid, output front_value, output back_value,
                    output entry_count, output status, input ready);
    modport sink   (input valid, input front_value, input back_value,
                    input entry_count, input status, output ready);
endinterface

[rtl/cdeq_cell.sv]
module cdeq_cell import cdeq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctrl        i_ctrl,
    input  logic [DATA_W-1:0] i_value,
    input  logic [DATA_W-1:0] i_left_data,
    input  logic              i_left_valid,
    input  logic [DATA_W-1:0] i_right_data,
    input  logic              i_right_valid,
    output logic [DATA_W-1:0] o_data,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_back_data
);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic              r_valid;
    logic              n_valid;

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        priority if (i_ctrl.add_front) begin
            n_data  = i_left_data;
            n_valid = i_left_valid;
        end else if (i_ctrl.add_back) begin
            // first empty cell takes the value
            if (!r_valid && i_left_valid) begin
                n_data  = i_value;
                n_valid = 1'b1;
            end
        end else if (i_ctrl.take_front) begin
            n_data  = i_right_data;
            n_valid = i_right_valid;
        end else if (i_ctrl.take_back) begin
            if (r_valid && !i_right_valid) begin
                n_valid = 1'b0;
            end
        end else begin
            // idle cycle: hold contents
            n_data  = r_data;
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_data      = r_data;
    assign o_valid     = r_valid;
    // last occupied cell drives the back value
    assign o_back_data = r_data & {DATA_W{r_valid && !i_right_valid}};

endmodule

[rtl/circular_double_ended_queue_top.sv]
// double-ended queue built as a row of shifting cells
//
// i_op  : operation transfers (operation, value); 0 push front, 1 push back,
//         2 pop front, 3 pop back
// o_res : one result transfer per operation: front and back entries, entry
//         count and status (0 done, 1 push rejected when full, 2 pop on empty)
//
// cell 0 always holds the front entry; valid bits form a thermometer, so the
// back entry is the last valid cell and is found locally by each cell
// result path: the cell row, count and r_pending register at the operation transfer
// edge; the result register then loads from the updated cells while r_pending is set
// issue: ready stays low in the cycle after a transfer while the result register
// loads, so the block does not take a new operation while the last result is loading
// reset: all cells invalid, count zero, no result pending
// a stalled receiver holds the result register; no new operation is taken
// until the pending result has been transferred (or is taken the same cycle)
module circular_double_ended_queue_top import cdeq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    cdeq_op_if.sink    i_op,
    cdeq_res_if.source o_res
);

    t_op               op;
    t_cell_ctrl        ctrl;
    t_status           status;
    logic              accept;
    logic              full;
    logic              empty;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_pending;
    t_status           r_status;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_front;
    logic [DATA_W-1:0] r_back;
    logic [CNT_W-1:0]  r_cnt_out;
    t_status           r_stat_out;

    // neighbor links of the cell row
    logic [DATA_W-1:0] cell_data  [DEPTH];
    logic              cell_valid [DEPTH];
    logic [DATA_W-1:0] cell_back  [DEPTH];
    logic [DATA_W-1:0] back_or;

    assign i_op.ready = !r_pending && (!r_out_valid || o_res.ready);
    assign accept     = i_op.valid && i_op.ready;
    assign op         = t_op'(i_op.operation);
    assign full       = (r_count == CNT_W'(DEPTH));
    assign empty      = (r_count == '0);

    // decode the operation, reject push on full and pop on empty
    always_comb begin
        ctrl    = '0;
        status  = ST_DONE;
        n_count = r_count;
        unique case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    ctrl.add_front = accept && (op == OP_PUSH_FRONT);
                    ctrl.add_back  = accept && (op == OP_PUSH_BACK);
                    n_count        = r_count + CNT_W'(1);
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    ctrl.take_front = accept && (op == OP_POP_FRONT);
                    ctrl.take_back  = accept && (op == OP_POP_BACK);
                    n_count         = r_count - CNT_W'(1);
                end
            end
            default: begin
                status = ST_DONE;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [DATA_W-1:0] left_data;
            logic              left_valid;
            logic [DATA_W-1:0] right_data;
            logic              right_valid;

            // cell 0 sees the pushed value as its left neighbor
            if (gi == 0) begin : g_head
                assign left_data  = i_op.value;
                assign left_valid = 1'b1;
            end else begin : g_mid
                assign left_data  = cell_data[gi-1];
                assign left_valid = cell_valid[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_tail
                assign right_data  = '0;
                assign right_valid = 1'b0;
            end else begin : g_body
                assign right_data  = cell_data[gi+1];
                assign right_valid = cell_valid[gi+1];
            end

            cdeq_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (ctrl),
                .i_value       (i_op.value),
                .i_left_data   (left_data),
                .i_left_valid  (left_valid),
                .i_right_data  (right_data),
                .i_right_valid (right_valid),
                .o_data        (cell_data[gi]),
                .o_valid       (cell_valid[gi]),
                .o_back_data   (cell_back[gi])
            );
        end
    endgenerate

    // only the last valid cell contributes, so an or gives the back entry
    always_comb begin
        back_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            back_or = back_or | cell_back[k];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pending <= accept;
            if (accept) begin
                r_count <= n_count;
            end
            if (r_pending) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= status;
        end
        if (r_pending) begin
            r_front    <= cell_valid[0] ? cell_data[0] : '0;
            r_back     <= back_or;
            r_cnt_out  <= r_count;
            r_stat_out <= r_status;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.front_value = r_front;
    assign o_res.back_value  = r_back;
    assign o_res.entry_count = r_cnt_out;
    assign o_res.status      = r_stat_out;

endmodule

[rtl/cdeq_checker.sv]
module cdeq_checker import cdeq_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [DATA_W-1:0] i_front_value,
    input logic [DATA_W-1:0] i_back_value,
    input logic [CNT_W-1:0]  i_entry_count,
    input logic [1:0]        i_status
);

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_entry_count <= CNT_W'(DEPTH))
        else $error("entry count above capacity");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_entry_count == '0) |-> (i_front_value == '0 && i_back_value == '0))
        else $error("empty queue shows nonzero entries");

    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == ST_FULL) |-> i_entry_count == CNT_W'(DEPTH))
        else $error("push rejected while not full");

    a_empty_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == ST_EMPTY) |-> i_entry_count == '0)
        else $error("pop ignored while not empty");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_front_value)
            && $stable(i_back_value) && $stable(i_entry_count) && $stable(i_status)))
        else $error("stalled result changed");

endmodule

bind circular_double_ended_queue_top cdeq_checker u_cdeq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_front_value (o_res.front_value),
    .i_back_value  (o_res.back_value),
    .i_entry_count (o_res.entry_count),
    .i_status      (o_res.status)
);

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import cdeq_pkg::*;

    localparam int IDX_W       = $clog2(DEPTH);
    localparam int RAND_ITEMS  = 1200;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int SETTLE_CYC  = 10;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    // one result transfer as seen on o_res
    typedef struct packed {
        logic [DATA_W-1:0] front;
        logic [DATA_W-1:0] back;
        logic [CNT_W-1:0]  count;
        t_status           status;
    } t_deque_res;

    // expectation attached to an operation: typed in by hand or left to the predictor
    typedef struct packed {
        logic       typed;
        t_deque_res res;
    } t_op_expect;

    typedef struct packed {
        t_op               op;
        logic [DATA_W-1:0] value;
        logic              typed;
        t_deque_res        res;
    } t_dir_row;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    // directed operations: empty pops, extreme values, wrap of the front index below
    // entry 0, fill up to full, pushes on full, then a pop from the full store
    localparam t_dir_row DIR_ROWS [25] = '{
        '{OP_POP_FRONT,  32'h0000_0000, 1'b1, '{32'h0000_0000, 32'h0000_0000, 5'd0, ST_EMPTY}},
        '{OP_POP_BACK,   32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 32'h0000_0000, 5'd0, ST_EMPTY}},
        '{OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd1, ST_DONE}},
        '{OP_PUSH_BACK,  32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 32'h0000_0000, 5'd2, ST_DONE}},
        '{OP_POP_BACK,   32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd1, ST_DONE}},
        '{OP_POP_FRONT,  32'h0000_0000, 1'b1, '{32'h0000_0000, 32'h0000_0000, 5'd0, ST_DONE}},
        '{OP_PUSH_BACK,  32'h0000_0001, 1'b1, '{32'h0000_0001, 32'h0000_0001, 5'd1, ST_DONE}},
        '{OP_PUSH_FRONT, 32'h8000_0000, 1'b1, '{32'h8000_0000, 32'h0000_0001, 5'd2, ST_DONE}},
        '{OP_PUSH_BACK,  32'h0000_0002, 1'b0, '0},
        '{OP_PUSH_FRONT, 32'h4000_0000, 1'b0, '0},
        '{OP_PUSH_BACK,  32'h0000_0004, 1'b0, '0},
        '{OP_PUSH_FRONT, 32'h2000_0000, 1'b0, '0},
        '{OP_PUSH_BACK,  32'h1234_5678, 1'b0, '0},
        '{OP_PUSH_FRONT, 32'h89AB_CDEF, 1'b0, '0},
        '{OP_PUSH_BACK,  32'h5555_5555, 1'b0, '0},
        '{OP_PUSH_FRONT, 32'hAAAA_AAAA, 1'b0, '0},
        '{OP_PUSH_BACK,  32'h0F0F_0F0F, 1'b0, '0},
        '{OP_PUSH_FRONT, 32'hF0F0_F0F0, 1'b0, '0},
        '{OP_PUSH_BACK,  32'h7FFF_FFFF, 1'b0, '0},
        '{OP_PUSH_FRONT, 32'hFFFF_FFFE, 1'b0, '0},
        '{OP_PUSH_BACK,  32'h0000_FFFF, 1'b0, '0},
        '{OP_PUSH_FRONT, 32'hFFFF_0000, 1'b0, '0},
        '{OP_PUSH_FRONT, 32'h3C3C_3C3C, 1'b0, '0},
        '{OP_PUSH_BACK,  32'hC3C3_C3C3, 1'b0, '0},
        '{OP_POP_FRONT,  32'h0000_0000, 1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;

    cdeq_op_if  op_ch ();
    cdeq_res_if res_ch ();

    circular_double_ended_queue_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (op_ch),
        .o_res   (res_ch)
    );

    // predictor state: circular store with head and tail indices
    logic [DATA_W-1:0] deque_mem [DEPTH];
    logic [IDX_W-1:0]  head_idx;
    logic [IDX_W-1:0]  tail_idx;
    logic [CNT_W-1:0]  fill_cnt;

    t_op_expect op_expects [$];       // one per driven operation, consumed at its transfer
    t_deque_res expected_results [$]; // results owed by the block, oldest first

    int errors;
    int n_checked;
    int n_ops;
    int n_rejected_full;
    int n_ignored_empty;
    int peak_fill;
    int burst_left;
    int cycle_cnt;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // deque behavior for one operation; updates the predictor state
    function automatic t_deque_res apply_deque_op(t_op op, logic [DATA_W-1:0] val);
        t_deque_res r;
        r.status = ST_DONE;
        if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
            if (fill_cnt == CNT_W'(DEPTH)) begin
                r.status = ST_FULL;
                n_rejected_full++;
            end else begin
                // an empty store restarts both indices at entry 0
                if (fill_cnt == '0) begin
                    head_idx = '0;
                    tail_idx = '0;
                end else if (op == OP_PUSH_FRONT) begin
                    head_idx = (head_idx == '0) ? LAST_IDX : head_idx - 1'b1;
                end else begin
                    tail_idx = (tail_idx == LAST_IDX) ? '0 : tail_idx + 1'b1;
                end
                deque_mem[(op == OP_PUSH_FRONT) ? head_idx : tail_idx] = val;
                fill_cnt++;
            end
        end else begin
            if (fill_cnt == '0) begin
                r.status = ST_EMPTY;
                n_ignored_empty++;
            end else begin
                if (op == OP_POP_FRONT)
                    head_idx = (head_idx == LAST_IDX) ? '0 : head_idx + 1'b1;
                else
                    tail_idx = (tail_idx == '0) ? LAST_IDX : tail_idx - 1'b1;
                fill_cnt--;
            end
        end
        // empty store reads as zero on both ends
        r.front = (fill_cnt == '0) ? '0 : deque_mem[head_idx];
        r.back  = (fill_cnt == '0) ? '0 : deque_mem[tail_idx];
        r.count = fill_cnt;
        if (int'(fill_cnt) > peak_fill)
            peak_fill = int'(fill_cnt);
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        $display("[%0t] result %0d: %s got %h, expected %h", $realtime, n_checked, field,
                 got, want);
        errors++;
    endtask

    // drives one operation and returns at the edge of its transfer; the sender
    // works in bursts and drops valid for a random gap between them
    task automatic issue_op(t_op op, logic [DATA_W-1:0] val, logic typed, t_deque_res want);
        int         gap;
        t_op_expect rec;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                       : $urandom_range(1, 24);
            if (gap != 0) begin
                op_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        rec.typed  = typed;
        rec.res    = want;
        op_expects = {op_expects, rec};
        op_ch.valid     <= 1'b1;
        op_ch.operation <= op;
        op_ch.value     <= val;
        @(posedge i_clk);
        while (!op_ch.ready) @(posedge i_clk);
        n_ops++;
    endtask

    // hold the sender off until every owed result has been transferred
    task automatic wait_for_results();
        op_ch.valid <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0 || op_expects.size() != 0) @(posedge i_clk);
    endtask

    // scoreboard: operation transfers create expectations, result transfers consume them
    always @(posedge i_clk) begin
        t_deque_res pred;
        t_deque_res want;
        t_op_expect rec;
        if (i_rst_n && op_ch.valid && op_ch.ready) begin
            pred = apply_deque_op(t_op'(op_ch.operation), op_ch.value);
            rec  = op_expects[0];
            op_expects.delete(0);
            expected_results = {expected_results, (rec.typed ? rec.res : pred)};
        end
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_results.size() == 0) begin
                $display("[%0t] result transfer with no operation pending", $realtime);
                errors++;
            end else begin
                want = expected_results[0];
                expected_results.delete(0);
                if (res_ch.front_value !== want.front)
                    report_mismatch("front_value", res_ch.front_value, want.front);
                if (res_ch.back_value !== want.back)
                    report_mismatch("back_value", res_ch.back_value, want.back);
                if (res_ch.entry_count !== want.count)
                    report_mismatch("entry_count", DATA_W'(res_ch.entry_count),
                                    DATA_W'(want.count));
                if (res_ch.status !== want.status)
                    report_mismatch("status", DATA_W'(res_ch.status), DATA_W'(want.status));
            end
            n_checked++;
        end
    end

    // receiver: switches between stall patterns, including open stretches
    initial begin
        t_rx_mode   rx_mode;
        int         rx_left;
        logic [7:0] rx_phase;
        rx_mode  = RX_OPEN;
        rx_left  = 0;
        rx_phase = '0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 200);
            end
            rx_left--;
            rx_phase++;
            case (rx_mode)
                RX_OPEN:   res_ch.ready <= 1'b1;
                RX_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: res_ch.ready <= ($urandom_range(0, 4) == 0);
                default:   res_ch.ready <= (rx_phase % 3 != 0) && (rx_phase[4:3] != 2'b11);
            endcase
        end
    end

    // watchdog on total cycles
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d results still owed", cycle_cnt,
                 expected_results.size());
        $display("circular_double_ended_queue_top test failed");
        $finish;
    end

    // stimulus
    initial begin
        int                push_pct;
        int                seg_left;
        int                pick;
        t_op               op;
        logic [DATA_W-1:0] val;

        errors          = 0;
        n_checked       = 0;
        n_ops           = 0;
        n_rejected_full = 0;
        n_ignored_empty = 0;
        peak_fill       = 0;
        burst_left      = 0;
        head_idx        = '0;
        tail_idx        = '0;
        fill_cnt        = '0;
        push_pct        = 50;
        seg_left        = 0;

        i_rst_n         <= 1'b0;
        op_ch.valid     <= 1'b0;
        op_ch.operation <= OP_PUSH_FRONT;
        op_ch.value     <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (DIR_ROWS[i])
            issue_op(DIR_ROWS[i].op, DIR_ROWS[i].value, DIR_ROWS[i].typed, DIR_ROWS[i].res);
        wait_for_results();

        // random part: segments lean toward filling, draining or churning so the
        // count keeps crossing between empty and full
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (seg_left == 0) begin
                case ($urandom_range(0, 4))
                    0:       push_pct = 85;
                    1:       push_pct = 15;
                    2:       push_pct = 55;
                    3:       push_pct = 45;
                    default: push_pct = 50;
                endcase
                seg_left = $urandom_range(10, 60);
            end
            seg_left--;

            // pause mid-run until the block has returned everything
            if (i == RAND_ITEMS / 2)
                wait_for_results();

            if ($urandom_range(0, 99) < push_pct)
                op = ($urandom_range(0, 1) != 0) ? OP_PUSH_FRONT : OP_PUSH_BACK;
            else
                op = ($urandom_range(0, 1) != 0) ? OP_POP_FRONT : OP_POP_BACK;

            // half random words, the rest all-zero, all-one, walking-one and walking-zero patterns
            pick = $urandom_range(0, 7);
            case (pick)
                0:       val = '0;
                1:       val = '1;
                2:       val = DATA_W'(1) << $urandom_range(0, DATA_W - 1);
                3:       val = ~(DATA_W'(1) << $urandom_range(0, DATA_W - 1));
                default: val = $urandom();
            endcase
            issue_op(op, val, 1'b0, '0);
        end

        wait_for_results();
        // keep the clock running to catch any stray result transfer
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("covered %0d operations: %0d pushes on a full store, %0d pops on an empty one",
                 n_ops, n_rejected_full, n_ignored_empty);
        $display("peak fill %0d of %0d entries, %0d results checked, %0d mismatches",
                 peak_fill, DEPTH, n_checked, errors);
        if (errors == 0) begin
            $display("circular_double_ended_queue_top test passed");
        end else begin
            $display("circular_double_ended_queue_top test failed");
        end
        $finish;
    end

endmodule

[files.f]
rtl/cdeq_pkg.sv
rtl/cdeq_if.sv
rtl/cdeq_cell.sv
rtl/circular_double_ended_queue_top.sv
rtl/cdeq_checker.sv
bench/testbench.sv
